@@ design/assert_macros.svh @@
// Assertion macros for the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)

`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ design/pidtc_pkg.sv @@
`timescale 1ns / 1ps

package pidtc_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int MS_PER_SECOND = 1000;
    localparam int TWO_SECONDS   = 2 * MS_PER_SECOND;
    localparam int REG_IDX_W     = 3;

    localparam logic [1:0] OP_RUN  = 2'd0;
    localparam logic [1:0] OP_STOP = 2'd1;
    localparam logic [1:0] OP_LOAD = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_MIN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_OUTPUT_MAX = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INT_LIMIT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD     = 3'd6;

    function automatic logic [31:0] sat_s33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_mag(input logic neg, input logic [64:0] m);
        logic [31:0] r;
        if (!neg)
        begin
            r = (m > 65'h0_7fff_ffff) ? 32'h7fff_ffff : m[31:0];
        end
        else
        begin
            r = (m > 65'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
        end
        return r;
    endfunction

    function automatic logic [32:0] mag33(input logic [32:0] v);
        logic [32:0] r;
        r = v[32] ? (33'd0 - v) : v;
        return r;
    endfunction

endpackage

@@ design/pid_trapezoid_clamped_top.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Content
// s_*     | in        | s_tvalid/s_tready  | request: operation, measurement, target, now_ms, load
// m_*     | out       | m_tvalid/m_tready  | result: output, terms, integral, flags
// cfg_*   | in        | cfg_valid/cfg_ready| register write: index and data
// A run request that updates uses one bit-serial multiplier and one restoring divider,
// shared by up to five multiplies and two divides.
// Other requests go straight from S_IDLE to S_OUT. One request is in work at a time.
// A finished result waits in the output register while the next request is taken.
// All state resets asynchronously on rst_n low to the documented values.
`include "assert_macros.svh"

module pid_trapezoid_clamped_top
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // measurement, target, now_ms, integral_load
    input  logic [127:0]                    s_tdata,
    // operation
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // control_out, p_term, i_term, d_term, integral_value
    output logic [159:0]                    m_tdata,
    // stopped_flag, updated
    output logic [1:0]                      m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pidtc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data
);
    import pidtc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_IMUL, S_IDIV, S_INTEG, S_RMUL, S_RDIV,
        S_GSET, S_GMUL, S_SUM, S_OUT
    } state_t;

    typedef enum logic [1:0] {G_P, G_I, G_D} gain_sel_t;

    state_t      state_reg;
    gain_sel_t   gsel_reg;
    logic [5:0]  cnt_reg;

    logic [31:0] gain_p_reg, gain_i_reg, gain_d_reg, out_min_reg, out_max_reg;
    logic [30:0] lim_reg;
    logic [15:0] period_reg;

    logic [31:0] last_reg, acc_reg, prev_reg, held_reg, p_reg, i_reg, d_reg;
    logic        stopped_reg;
    logic [31:0] e_reg, dt_reg, rate_reg, ctl_reg;
    logic        upd_reg, neg_reg;

    logic [64:0] mul_p_reg;
    logic [32:0] mul_a_reg;
    logic [63:0] div_d_reg;
    logic [31:0] div_v_reg, rem_reg;

    logic        m_valid_reg;
    logic [159:0] m_data_reg;
    logic [1:0]  m_user_reg;

    logic        accept;
    logic [31:0] in_meas, in_targ, in_now, in_load;
    logic [31:0] e_in, dt_in;
    logic [33:0] mul_sum;
    logic [32:0] div_sh;
    logic        div_ge;
    logic [32:0] ep_sum, de_val;
    logic [31:0] inc_val, acc_sat, acc_clamped;
    logic signed [31:0] lim_pos, lim_neg;
    logic [31:0] g_sel, v_sel, term_val;
    logic signed [33:0] pid_sum;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    assign in_meas = s_tdata[31:0];
    assign in_targ = s_tdata[63:32];
    assign in_now  = s_tdata[95:64];
    assign in_load = s_tdata[127:96];
    assign e_in    = sat_s33({in_targ[31], in_targ} - {in_meas[31], in_meas});
    assign dt_in   = in_now - last_reg;

    assign mul_sum = {1'b0, mul_p_reg[64:32]} + (mul_p_reg[0] ? {1'b0, mul_a_reg} : 34'd0);
    assign div_sh  = {rem_reg, div_d_reg[63]};
    assign div_ge  = (div_sh >= {1'b0, div_v_reg});

    assign ep_sum  = {e_reg[31], e_reg} + {prev_reg[31], prev_reg};
    assign de_val  = {e_reg[31], e_reg} - {prev_reg[31], prev_reg};
    assign inc_val = sat_mag(neg_reg, {1'b0, div_d_reg});
    assign acc_sat = sat_s33({acc_reg[31], acc_reg} + {inc_val[31], inc_val});
    assign lim_pos = $signed({1'b0, lim_reg});
    assign lim_neg = -lim_pos;

    always_comb
    begin
        acc_clamped = acc_sat;
        if (lim_reg != 31'd0)
        begin
            if ($signed(acc_sat) < lim_neg)
            begin
                acc_clamped = lim_neg;
            end
            else if ($signed(acc_sat) > lim_pos)
            begin
                acc_clamped = lim_pos;
            end
        end
    end

    always_comb
    begin
        case (gsel_reg)
            G_P:
            begin
                g_sel = gain_p_reg;
                v_sel = e_reg;
            end
            G_I:
            begin
                g_sel = gain_i_reg;
                v_sel = acc_reg;
            end
            default:
            begin
                g_sel = gain_d_reg;
                v_sel = rate_reg;
            end
        endcase
    end

    assign term_val = sat_mag(neg_reg, {{FRAC_BITS{1'b0}}, mul_p_reg[64:FRAC_BITS]});
    assign pid_sum  = $signed({{2{p_reg[31]}}, p_reg}) + $signed({{2{i_reg[31]}}, i_reg})
                    + $signed({{2{d_reg[31]}}, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            gsel_reg    <= G_P;
            cnt_reg     <= '0;
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            out_min_reg <= 32'h8000_0000;
            out_max_reg <= 32'h7fff_ffff;
            lim_reg     <= '0;
            period_reg  <= 16'(MS_PER_SECOND);
            last_reg    <= '0;
            acc_reg     <= '0;
            prev_reg    <= '0;
            held_reg    <= '0;
            p_reg       <= '0;
            i_reg       <= '0;
            d_reg       <= '0;
            stopped_reg <= 1'b0;
            e_reg       <= '0;
            dt_reg      <= '0;
            rate_reg    <= '0;
            ctl_reg     <= '0;
            upd_reg     <= 1'b0;
            neg_reg     <= 1'b0;
            mul_p_reg   <= '0;
            mul_a_reg   <= '0;
            div_d_reg   <= '0;
            div_v_reg   <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GAIN_P:     gain_p_reg  <= cfg_data;
                    REG_GAIN_I:     gain_i_reg  <= cfg_data;
                    REG_GAIN_D:     gain_d_reg  <= cfg_data;
                    REG_OUTPUT_MIN: out_min_reg <= cfg_data;
                    REG_OUTPUT_MAX: out_max_reg <= cfg_data;
                    REG_INT_LIMIT:  lim_reg     <= cfg_data[30:0];
                    REG_PERIOD:     period_reg  <= cfg_data[15:0];
                    default:        ;
                endcase
            end

            if (m_valid_reg && m_tready && state_reg != S_OUT)
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ctl_reg   <= held_reg;
                        upd_reg   <= 1'b0;
                        state_reg <= S_OUT;
                        case (s_tuser)
                            OP_RUN:
                            begin
                                if (stopped_reg)
                                begin
                                    stopped_reg <= 1'b0;
                                    last_reg    <= in_now;
                                    acc_reg     <= '0;
                                    prev_reg    <= '0;
                                    ctl_reg     <= '0;
                                end
                                else if (dt_in >= {16'd0, period_reg})
                                begin
                                    last_reg  <= in_now;
                                    e_reg     <= e_in;
                                    dt_reg    <= dt_in;
                                    state_reg <= S_PREP;
                                end
                            end
                            OP_STOP:
                            begin
                                stopped_reg <= 1'b1;
                                last_reg    <= in_now;
                                acc_reg     <= '0;
                                prev_reg    <= '0;
                            end
                            OP_LOAD:
                            begin
                                acc_reg <= in_load;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PREP:
                begin
                    mul_a_reg <= mag33(ep_sum);
                    mul_p_reg <= {33'd0, dt_reg};
                    neg_reg   <= ep_sum[32];
                    cnt_reg   <= '0;
                    state_reg <= S_IMUL;
                end
                S_IMUL, S_RMUL, S_GMUL:
                begin
                    if (state_reg == S_GMUL && cnt_reg == 6'd32)
                    begin
                        cnt_reg <= '0;
                        case (gsel_reg)
                            G_P:
                            begin
                                p_reg    <= term_val;
                                gsel_reg <= G_I;
                                state_reg <= S_GSET;
                            end
                            G_I:
                            begin
                                i_reg    <= term_val;
                                gsel_reg <= G_D;
                                state_reg <= S_GSET;
                            end
                            default:
                            begin
                                d_reg    <= term_val;
                                gsel_reg <= G_P;
                                state_reg <= S_SUM;
                            end
                        endcase
                    end
                    else
                    begin
                        mul_p_reg <= {mul_sum, mul_p_reg[31:1]};
                        if (cnt_reg == 6'd31 && state_reg != S_GMUL)
                        begin
                            cnt_reg   <= '0;
                            rem_reg   <= '0;
                            div_d_reg <= {mul_sum[32:0], mul_p_reg[31:1]};
                            if (state_reg == S_IMUL)
                            begin
                                div_v_reg <= 32'(TWO_SECONDS);
                                state_reg <= S_IDIV;
                            end
                            else
                            begin
                                div_v_reg <= dt_reg;
                                state_reg <= S_RDIV;
                            end
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 6'd1;
                        end
                    end
                end
                S_IDIV, S_RDIV:
                begin
                    rem_reg   <= div_ge ? 32'(div_sh - {1'b0, div_v_reg}) : div_sh[31:0];
                    div_d_reg <= {div_d_reg[62:0], div_ge};
                    if (cnt_reg == 6'd63)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (state_reg == S_IDIV) ? S_INTEG : S_GSET;
                        if (state_reg == S_RDIV)
                        begin
                            rate_reg <= sat_mag(neg_reg, {1'b0, div_d_reg[62:0], div_ge});
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                S_INTEG:
                begin
                    acc_reg  <= acc_clamped;
                    prev_reg <= e_reg;
                    neg_reg  <= de_val[32];
                    cnt_reg  <= '0;
                    if (dt_reg == 32'd0)
                    begin
                        rate_reg  <= '0;
                        state_reg <= S_GSET;
                    end
                    else
                    begin
                        mul_a_reg <= mag33(de_val);
                        mul_p_reg <= {33'd0, 32'(MS_PER_SECOND)};
                        state_reg <= S_RMUL;
                    end
                end
                S_GSET:
                begin
                    mul_a_reg <= mag33({g_sel[31], g_sel});
                    mul_p_reg <= {33'd0, 32'(mag33({v_sel[31], v_sel}))};
                    neg_reg   <= g_sel[31] ^ v_sel[31];
                    cnt_reg   <= '0;
                    state_reg <= S_GMUL;
                end
                S_SUM:
                begin
                    if (pid_sum < $signed({{2{out_min_reg[31]}}, out_min_reg}))
                    begin
                        held_reg <= out_min_reg;
                        ctl_reg  <= out_min_reg;
                    end
                    else if (pid_sum > $signed({{2{out_max_reg[31]}}, out_max_reg}))
                    begin
                        held_reg <= out_max_reg;
                        ctl_reg  <= out_max_reg;
                    end
                    else
                    begin
                        held_reg <= pid_sum[31:0];
                        ctl_reg  <= pid_sum[31:0];
                    end
                    upd_reg   <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {acc_reg, d_reg, i_reg, p_reg, ctl_reg};
                        m_user_reg  <= {upd_reg, stopped_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `ASSERT_NEXT(a_run_clears_stop, clk, rst_n, accept && s_tuser == OP_RUN && stopped_reg, !stopped_reg)
    `ASSERT_IMPLY(a_upd_not_stopped, clk, rst_n, m_tvalid && m_tuser[1], !m_tuser[0])
    `ASSERT_IMPLY(a_busy_no_ready, clk, rst_n, state_reg == S_GMUL || state_reg == S_RDIV, !s_tready)

endmodule
